/* src/per_label_binned_histogram_assert.svh */
// ----------------------------------------------------------------------------
// Assertion macros for the per-label binned histogram
// Concurrent checks clocked on clk and disabled while rst is high.
// ----------------------------------------------------------------------------
`ifndef PER_LABEL_BINNED_HISTOGRAM_ASSERT_SVH
`define PER_LABEL_BINNED_HISTOGRAM_ASSERT_SVH

// Condition holds at every edge out of reset
`define PLBH_ASSERT_ALWAYS(name, cond, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// Antecedent implies consequent in the same cycle
`define PLBH_ASSERT_IMPLY(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

`endif

/* src/plbh_pkg.sv */
// ----------------------------------------------------------------------------
// plbh_pkg
// Shared constants, types and helper functions of the per-label histogram.
// ----------------------------------------------------------------------------
`default_nettype none

package plbh_pkg;

  localparam int LABEL_COUNT = 256;
  localparam int COUNT_WIDTH = 32;
  localparam int BIN_SLOTS   = 256;
  localparam int BIN_W       = 8;
  localparam int LABEL_W     = $clog2(LABEL_COUNT);
  localparam int ADDR_W      = LABEL_W + BIN_W;
  localparam int MEM_DEPTH   = LABEL_COUNT * BIN_SLOTS;
  localparam int OUT_W       = 32;
  localparam int CLIP_W      = (COUNT_WIDTH > OUT_W) ? COUNT_WIDTH : OUT_W;
  localparam logic [OUT_W-1:0] OUT_MAX = '1;

  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_AW    = $clog2(FIFO_DEPTH);

  localparam int DIV_STEPS = 8;
  localparam int DIV_CW    = $clog2(DIV_STEPS);

  // request codes
  localparam logic REQ_ACCUM = 1'b0;
  localparam logic REQ_READ  = 1'b1;

  // configuration map: word index bit of paddr
  localparam int   CFG_AW        = 3;
  localparam logic CFG_BIN_WIDTH = 1'b0;
  localparam logic [7:0] BIN_WIDTH_RESET = 8'd1;

  typedef struct packed {
    logic               is_read;
    logic               lab_ok;
    logic [LABEL_W-1:0] lab_idx;
    logic [BIN_W-1:0]   bin;
  } op_t;

  typedef enum logic [1:0] {
    FR_IDLE,
    FR_DIV,
    FR_EMIT
  } front_state_t;

  typedef enum logic [1:0] {
    BK_CLEAR,
    BK_IDLE,
    BK_LOOK
  } back_state_t;

  function automatic logic [COUNT_WIDTH-1:0] sat_inc(input logic [COUNT_WIDTH-1:0] v);
    logic [COUNT_WIDTH-1:0] r;
    if (v == '1) begin
      r = v;
    end else begin
      r = v + COUNT_WIDTH'(1);
    end
    return r;
  endfunction

  function automatic logic [OUT_W-1:0] out_clip(input logic [COUNT_WIDTH-1:0] v);
    logic [CLIP_W-1:0] ext;
    logic [OUT_W-1:0]  r;
    ext = CLIP_W'(v);
    if (ext > CLIP_W'(OUT_MAX)) begin
      r = OUT_MAX;
    end else begin
      r = ext[OUT_W-1:0];
    end
    return r;
  endfunction

endpackage

`default_nettype wire

/* src/per_label_binned_histogram.sv */
// Path: a read goes through the front's op register, the queue and the back's
//   read registers into the result register; an accumulate ends in a write.
// Flow: the back does one op at a time, and the front takes no new transaction
//   until it has queued the last; accumulates pass the one-bit-per-cycle divider.
// Reset: rst clears both count memories in one pass over the LABEL_COUNT*256
//   bin entries (65536), one entry per cycle; full stays high until it ends.
// ----------------------------------------------------------------------------
// per_label_binned_histogram
// Per-label histogram of 8-bit pixel values with saturating bin and label
// counters, a bin-width register on an APB port and queue-style channels.
// ----------------------------------------------------------------------------
`default_nettype none

`include "per_label_binned_histogram_assert.svh"

module per_label_binned_histogram (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          psel,
  input  wire logic                          penable,
  input  wire logic                          pwrite,
  input  wire logic [plbh_pkg::CFG_AW-1:0]   paddr,
  input  wire logic [31:0]                   pwdata,
  output      logic [31:0]                   prdata,
  output      logic                          pready,
  input  wire logic                          push,
  output      logic                          full,
  input  wire logic                          req_type,
  input  wire logic [7:0]                    label,
  input  wire logic [7:0]                    pixel_value,
  input  wire logic [7:0]                    bin,
  output      logic                          empty,
  input  wire logic                          pop,
  output      logic [plbh_pkg::OUT_W-1:0]    bin_count,
  output      logic [plbh_pkg::OUT_W-1:0]    label_total,
  output      logic                          label_present
);
  import plbh_pkg::*;

  logic [7:0] bin_width;
  logic       clearing;
  logic       q_push;
  logic       q_full;
  logic       q_pop;
  logic       q_empty;
  op_t        q_in;
  op_t        q_out;

  assign pready = 1'b1;
  assign prdata = (paddr[2] == CFG_BIN_WIDTH) ? 32'(bin_width) : 32'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      bin_width <= BIN_WIDTH_RESET;
    end else if (psel && penable && pwrite && pready && (paddr[2] == CFG_BIN_WIDTH)) begin
      bin_width <= pwdata[7:0];
    end
  end

  plbh_front u_front (
    .clk         (clk),
    .rst         (rst),
    .push        (push),
    .full        (full),
    .req_type    (req_type),
    .label       (label),
    .pixel_value (pixel_value),
    .bin         (bin),
    .bin_width   (bin_width),
    .clearing    (clearing),
    .q_full      (q_full),
    .q_push      (q_push),
    .q_data      (q_in)
  );

  plbh_fifo u_fifo (
    .clk   (clk),
    .rst   (rst),
    .push  (q_push),
    .din   (q_in),
    .full  (q_full),
    .pop   (q_pop),
    .dout  (q_out),
    .empty (q_empty)
  );

  plbh_back u_back (
    .clk           (clk),
    .rst           (rst),
    .q_empty       (q_empty),
    .q_data        (q_out),
    .q_pop         (q_pop),
    .clearing      (clearing),
    .empty         (empty),
    .pop           (pop),
    .bin_count     (bin_count),
    .label_total   (label_total),
    .label_present (label_present)
  );

  `PLBH_ASSERT_IMPLY(a_clear_blocks_input, clearing, full, "transaction accepted during clear")
  `PLBH_ASSERT_IMPLY(a_clear_queue_idle, clearing, q_empty, "queue holds ops during clear")
  `PLBH_ASSERT_ALWAYS(a_no_queue_overflow, !(q_push && q_full), "push into full queue")

endmodule

`default_nettype wire

/* src/plbh_front.sv */
// ----------------------------------------------------------------------------
// plbh_front
// Accepts transactions, finds the bin of an accumulate with a bit-serial
// divider and hands one classified operation to the queue.
// ----------------------------------------------------------------------------
`default_nettype none

module plbh_front (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            push,
  output      logic            full,
  input  wire logic            req_type,
  input  wire logic [7:0]      label,
  input  wire logic [7:0]      pixel_value,
  input  wire logic [7:0]      bin,
  input  wire logic [7:0]      bin_width,
  input  wire logic            clearing,
  input  wire logic            q_full,
  output      logic            q_push,
  output      plbh_pkg::op_t   q_data
);
  import plbh_pkg::*;

  front_state_t        state;
  front_state_t        state_next;
  op_t                 op;
  logic [7:0]          dvd;
  logic [7:0]          rem;
  logic [7:0]          w;
  logic [DIV_CW-1:0]   cnt;
  logic                accept;
  logic [8:0]          shifted;
  logic [8:0]          trial;
  logic                qbit;

  assign shifted = {rem, dvd[7]};
  assign trial   = shifted - {1'b0, w};
  assign qbit    = ~trial[8];

  always_comb begin
    state_next = state;
    unique case (state)
      FR_IDLE: begin
        if (push && !clearing) begin
          state_next = (req_type == REQ_READ) ? FR_EMIT : FR_DIV;
        end
      end
      FR_DIV: begin
        if (cnt == DIV_CW'(DIV_STEPS - 1)) begin
          state_next = FR_EMIT;
        end
      end
      FR_EMIT: begin
        if (!q_full) begin
          state_next = FR_IDLE;
        end
      end
      default: state_next = FR_IDLE;
    endcase
  end

  always_comb begin
    full   = 1'b1;
    q_push = 1'b0;
    unique case (state)
      FR_IDLE: full   = clearing;
      FR_DIV:  full   = 1'b1;
      FR_EMIT: q_push = !q_full;
      default: full   = 1'b1;
    endcase
  end

  assign accept = push && !full;

  always_comb begin
    q_data = op;
    if (!op.is_read) begin
      q_data.bin = dvd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= FR_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      op.is_read <= (req_type == REQ_READ);
      op.lab_ok  <= (int'(label) < LABEL_COUNT);
      op.lab_idx <= LABEL_W'(label);
      op.bin     <= bin;
      dvd        <= pixel_value;
      rem        <= '0;
      cnt        <= '0;
      w          <= (bin_width == 8'd0) ? 8'd1 : bin_width;
    end else if (state == FR_DIV) begin
      rem <= qbit ? trial[7:0] : shifted[7:0];
      dvd <= {dvd[6:0], qbit};
      cnt <= cnt + DIV_CW'(1);
    end
  end

endmodule

`default_nettype wire

/* src/plbh_fifo.sv */
// ----------------------------------------------------------------------------
// plbh_fifo
// Short operation queue between the front and back sections.
// ----------------------------------------------------------------------------
`default_nettype none

module plbh_fifo (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            push,
  input  wire plbh_pkg::op_t   din,
  output      logic            full,
  input  wire logic            pop,
  output      plbh_pkg::op_t   dout,
  output      logic            empty
);
  import plbh_pkg::*;

  op_t              entries [FIFO_DEPTH];
  logic [FIFO_AW:0] wr_ptr;
  logic [FIFO_AW:0] rd_ptr;

  assign empty = (wr_ptr == rd_ptr);
  assign full  = (wr_ptr[FIFO_AW-1:0] == rd_ptr[FIFO_AW-1:0]) &&
                 (wr_ptr[FIFO_AW] != rd_ptr[FIFO_AW]);
  assign dout  = entries[rd_ptr[FIFO_AW-1:0]];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
    end else begin
      if (push && !full) begin
        wr_ptr <= wr_ptr + (FIFO_AW + 1)'(1);
      end
      if (pop && !empty) begin
        rd_ptr <= rd_ptr + (FIFO_AW + 1)'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push && !full) begin
      entries[wr_ptr[FIFO_AW-1:0]] <= din;
    end
  end

endmodule

`default_nettype wire

/* src/plbh_back.sv */
// ----------------------------------------------------------------------------
// plbh_back
// Owns the count memories: clears them after reset, then runs one
// read-modify-write or lookup per queued operation into a result register.
// ----------------------------------------------------------------------------
`default_nettype none

module plbh_back (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      q_empty,
  input  wire plbh_pkg::op_t             q_data,
  output      logic                      q_pop,
  output      logic                      clearing,
  output      logic                      empty,
  input  wire logic                      pop,
  output      logic [plbh_pkg::OUT_W-1:0] bin_count,
  output      logic [plbh_pkg::OUT_W-1:0] label_total,
  output      logic                      label_present
);
  import plbh_pkg::*;

  localparam logic [ADDR_W-1:0] CLR_LAST = ADDR_W'(MEM_DEPTH - 1);

  logic [COUNT_WIDTH-1:0] bin_mem [MEM_DEPTH];
  logic [COUNT_WIDTH-1:0] tot_mem [LABEL_COUNT];

  back_state_t            state;
  back_state_t            state_next;
  op_t                    cur;
  logic [ADDR_W-1:0]      clr_addr;
  logic                   out_valid;

  logic                   rd_en;
  logic [ADDR_W-1:0]      rd_addr;
  logic [COUNT_WIDTH-1:0] bin_rd;
  logic [COUNT_WIDTH-1:0] tot_rd;

  logic                   bin_we;
  logic [ADDR_W-1:0]      bin_waddr;
  logic [COUNT_WIDTH-1:0] bin_wdata;
  logic                   tot_we;
  logic [LABEL_W-1:0]     tot_waddr;
  logic [COUNT_WIDTH-1:0] tot_wdata;
  logic                   load_out;
  logic                   done;

  assign rd_addr = {q_data.lab_idx, q_data.bin};
  assign empty   = !out_valid;

  always_comb begin
    state_next = state;
    unique case (state)
      BK_CLEAR: begin
        if (clr_addr == CLR_LAST) begin
          state_next = BK_IDLE;
        end
      end
      BK_IDLE: begin
        if (!q_empty) begin
          state_next = BK_LOOK;
        end
      end
      BK_LOOK: begin
        if (done) begin
          state_next = BK_IDLE;
        end
      end
      default: state_next = BK_CLEAR;
    endcase
  end

  always_comb begin
    clearing  = 1'b0;
    q_pop     = 1'b0;
    rd_en     = 1'b0;
    bin_we    = 1'b0;
    bin_waddr = clr_addr;
    bin_wdata = '0;
    tot_we    = 1'b0;
    tot_waddr = clr_addr[ADDR_W-1:BIN_W];
    tot_wdata = '0;
    load_out  = 1'b0;
    done      = 1'b0;
    unique case (state)
      BK_CLEAR: begin
        clearing = 1'b1;
        bin_we   = 1'b1;
        tot_we   = 1'b1;
      end
      BK_IDLE: begin
        q_pop = !q_empty;
        rd_en = !q_empty;
      end
      BK_LOOK: begin
        if (cur.is_read) begin
          load_out = !out_valid || pop;
          done     = load_out;
        end else begin
          done      = 1'b1;
          bin_we    = cur.lab_ok;
          tot_we    = cur.lab_ok;
          bin_waddr = {cur.lab_idx, cur.bin};
          tot_waddr = cur.lab_idx;
          bin_wdata = sat_inc(bin_rd);
          tot_wdata = sat_inc(tot_rd);
        end
      end
      default: clearing = 1'b1;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= BK_CLEAR;
      clr_addr  <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (state == BK_CLEAR) begin
        clr_addr <= clr_addr + ADDR_W'(1);
      end
      if (load_out) begin
        out_valid <= 1'b1;
      end else if (pop && out_valid) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (bin_we) begin
      bin_mem[bin_waddr] <= bin_wdata;
    end
    if (rd_en) begin
      bin_rd <= bin_mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (tot_we) begin
      tot_mem[tot_waddr] <= tot_wdata;
    end
    if (rd_en) begin
      tot_rd <= tot_mem[q_data.lab_idx];
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      cur <= q_data;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      if (cur.lab_ok) begin
        bin_count     <= out_clip(bin_rd);
        label_total   <= out_clip(tot_rd);
        label_present <= (tot_rd != '0);
      end else begin
        bin_count     <= '0;
        label_total   <= '0;
        label_present <= 1'b0;
      end
    end
  end

endmodule

`default_nettype wire

/* test/per_label_binned_histogram_tb.sv */
// ----------------------------------------------------------------------------
// per_label_binned_histogram_tb
// Self-checking bench for the per-label histogram. Accumulate and read
// transactions go in through the push/full port; a scoreboard keeps its own
// copy of the bin and label counters and checks every popped result field by
// field. The bin width is reprogrammed over APB between phases while idle.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module per_label_binned_histogram_tb;
  import plbh_pkg::*;

  localparam logic [CFG_AW-1:0] BIN_WIDTH_ADDR = CFG_AW'(4 * int'(CFG_BIN_WIDTH));
  localparam int SETTLE_CYCLES = 40;
  localparam int PHASE_ITEMS   = 95;

  typedef struct {
    logic [OUT_W-1:0] bin_count;
    logic [OUT_W-1:0] label_total;
    logic             label_present;
  } cell_read_t;

  class histogram_scoreboard;
    bit [COUNT_WIDTH-1:0] cell_count [0:MEM_DEPTH-1];
    bit [COUNT_WIDTH-1:0] label_sum [0:LABEL_COUNT-1];
    bit [7:0]             width_reg;
    cell_read_t           pending_q [$];
    int                   errors;
    int                   checked;

    function new();
      width_reg = BIN_WIDTH_RESET;
      errors    = 0;
      checked   = 0;
    endfunction

    function bit [COUNT_WIDTH-1:0] bump(bit [COUNT_WIDTH-1:0] v);
      return (v == '1) ? v : v + 1'b1;
    endfunction

    function logic [OUT_W-1:0] clip(bit [COUNT_WIDTH-1:0] v);
      return (64'(v) > 64'(OUT_MAX)) ? OUT_MAX : OUT_W'(v);
    endfunction

    task report(string msg);
      if (errors < 100) $display("mismatch: %s", msg);
      errors++;
    endtask

    function void note_input(logic rt, logic [7:0] lab, logic [7:0] pix, logic [7:0] bn);
      int         w;
      int         idx;
      cell_read_t r;
      w = (width_reg == 0) ? 1 : int'(width_reg);
      if (rt == REQ_ACCUM) begin
        if (int'(lab) < LABEL_COUNT) begin
          idx = int'(lab) * BIN_SLOTS + ((int'(pix) / w) % BIN_SLOTS);
          cell_count[idx] = bump(cell_count[idx]);
          label_sum[lab]  = bump(label_sum[lab]);
        end
      end else begin
        if (int'(lab) < LABEL_COUNT) begin
          idx = int'(lab) * BIN_SLOTS + int'(bn);
          r.bin_count     = clip(cell_count[idx]);
          r.label_total   = clip(label_sum[lab]);
          r.label_present = (label_sum[lab] != 0);
        end else begin
          r.bin_count     = '0;
          r.label_total   = '0;
          r.label_present = 1'b0;
        end
        pending_q.push_back(r);
      end
    endfunction

    task check_result(logic [OUT_W-1:0] bc, logic [OUT_W-1:0] lt, logic lp);
      cell_read_t e;
      if (pending_q.size() == 0) begin
        report($sformatf("unexpected result count=%0d total=%0d present=%0b", bc, lt, lp));
      end else begin
        e = pending_q.pop_front();
        checked++;
        if (bc !== e.bin_count)
          report($sformatf("result %0d bin_count %0d, want %0d", checked, bc, e.bin_count));
        if (lt !== e.label_total)
          report($sformatf("result %0d label_total %0d, want %0d", checked, lt,
                           e.label_total));
        if (lp !== e.label_present)
          report($sformatf("result %0d label_present %0b, want %0b", checked, lp,
                           e.label_present));
      end
    endtask

    task finish_check();
      if (pending_q.size() != 0)
        report($sformatf("%0d results never arrived", pending_q.size()));
    endtask
  endclass

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                psel = 1'b0;
  logic                penable = 1'b0;
  logic                pwrite = 1'b0;
  logic [CFG_AW-1:0]   paddr = '0;
  logic [31:0]         pwdata = '0;
  logic [31:0]         prdata;
  logic                pready;
  logic                push = 1'b0;
  logic                full;
  logic                req_type = REQ_ACCUM;
  logic [7:0]          label = '0;
  logic [7:0]          pixel_value = '0;
  logic [7:0]          bin = '0;
  logic                empty;
  logic                pop = 1'b0;
  logic [OUT_W-1:0]    bin_count;
  logic [OUT_W-1:0]    label_total;
  logic                label_present;

  logic                rx_idle = 1'b1;
  logic                squeeze = 1'b0;
  bit                  tx_idle = 1'b1;
  bit [7:0]            hot_labels [8];
  int                  items_sent = 0;
  int                  reads_sent = 0;
  int                  widths_used = 0;

  histogram_scoreboard sb = new();

  per_label_binned_histogram dut (.*);

  initial begin
    forever #5 clk = ~clk;
  end

  initial begin
    #5_000_000;
    $display("tb: failure");
    $finish;
  end

  task automatic send_item(logic rt, logic [7:0] lab, logic [7:0] pix, logic [7:0] bn);
    if (tx_idle && $urandom_range(0, 3) == 0) begin
      push <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk);
    end
    push        <= 1'b1;
    req_type    <= rt;
    label       <= lab;
    pixel_value <= pix;
    bin         <= bn;
    do @(posedge clk); while (full);
    sb.note_input(rt, lab, pix, bn);
    items_sent++;
    if (rt == REQ_READ) reads_sent++;
  endtask

  task automatic send_random();
    logic     rt;
    logic [7:0] lab;
    logic [7:0] pix;
    logic [7:0] bn;
    int       w;
    w = (sb.width_reg == 0) ? 1 : int'(sb.width_reg);
    if ($urandom_range(0, 99) < 15) begin
      rt  = 1'($urandom);
      lab = 8'($urandom);
      pix = 8'($urandom);
      bn  = 8'($urandom);
    end else begin
      rt  = ($urandom_range(0, 99) < 40) ? REQ_READ : REQ_ACCUM;
      lab = hot_labels[$urandom_range(0, 7)];
      pix = 8'($urandom);
      bn  = ($urandom_range(0, 9) == 0) ? 8'($urandom) : 8'($urandom_range(0, 255) / w);
    end
    send_item(rt, lab, pix, bn);
  endtask

  // wait for every read result, then let in-flight accumulates finish
  task automatic settle();
    push <= 1'b0;
    while (sb.pending_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic program_bin_width(logic [7:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= BIN_WIDTH_ADDR;
    pwdata  <= 32'(value);
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    sb.width_reg = value;
    widths_used++;
    @(posedge clk);
    psel    <= 1'b1;
    pwrite  <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (prdata !== 32'(value))
      sb.report($sformatf("bin_width reads %0d, want %0d", prdata, value));
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  initial begin : result_sink
    int stall_left;
    bit squeezed;
    stall_left = 0;
    squeezed   = 1'b0;
    forever begin
      @(posedge clk);
      if (pop && !empty) sb.check_result(bin_count, label_total, label_present);
      if (squeeze && !squeezed) begin
        squeezed   = 1'b1;
        stall_left = 120;
      end else if (stall_left == 0 && rx_idle && $urandom_range(0, 3) == 0) begin
        stall_left = $urandom_range(1, 5);
      end
      if (stall_left > 0) begin
        pop <= 1'b0;
        stall_left--;
      end else begin
        pop <= 1'b1;
      end
    end
  end

  initial begin : stimulus
    bit [7:0] widths [10];
    widths = '{8'd1, 8'd255, 8'd0, 8'd2, 8'd3, 8'd16, 8'd100, 8'd128, 8'd0, 8'd0};
    widths[8] = 8'($urandom_range(1, 255));
    widths[9] = 8'($urandom_range(1, 255));
    hot_labels[0] = 8'd0;
    hot_labels[1] = 8'd255;
    for (int i = 2; i < 8; i++) hot_labels[i] = 8'($urandom);

    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // reset width of one, unseen label, extremes of label and pixel
    send_item(REQ_READ,  8'd0,   8'd0,   8'd0);
    send_item(REQ_ACCUM, 8'd0,   8'd0,   8'd255);
    send_item(REQ_ACCUM, 8'd255, 8'd255, 8'd0);
    send_item(REQ_ACCUM, 8'd0,   8'd255, 8'd0);
    send_item(REQ_ACCUM, 8'd255, 8'd0,   8'd255);
    send_item(REQ_ACCUM, 8'd0,   8'd0,   8'd0);
    send_item(REQ_READ,  8'd0,   8'd0,   8'd0);
    send_item(REQ_READ,  8'd0,   8'd0,   8'd255);
    send_item(REQ_READ,  8'd255, 8'd0,   8'd255);
    send_item(REQ_READ,  8'd255, 8'd255, 8'd0);
    send_item(REQ_READ,  8'd0,   8'd0,   8'd128);
    send_item(REQ_READ,  8'd17,  8'd0,   8'd3);
    settle();
    // zero width behaves as one
    program_bin_width(8'd0);
    send_item(REQ_ACCUM, 8'd5,   8'd200, 8'd0);
    send_item(REQ_READ,  8'd5,   8'd0,   8'd200);
    settle();
    // widest bin: only bins 0 and 1 reachable
    program_bin_width(8'd255);
    send_item(REQ_ACCUM, 8'd5,   8'd254, 8'd0);
    send_item(REQ_ACCUM, 8'd5,   8'd255, 8'd0);
    send_item(REQ_READ,  8'd5,   8'd0,   8'd0);
    send_item(REQ_READ,  8'd5,   8'd0,   8'd1);
    send_item(REQ_READ,  8'd5,   8'd0,   8'd2);
    send_item(REQ_READ,  8'd5,   8'd0,   8'd255);
    settle();
    // width change keeps old counts in place
    program_bin_width(8'd16);
    send_item(REQ_READ,  8'd5,   8'd0,   8'd200);
    send_item(REQ_ACCUM, 8'd5,   8'd200, 8'd0);
    send_item(REQ_READ,  8'd5,   8'd0,   8'd12);

    for (int p = 0; p < 10; p++) begin
      settle();
      program_bin_width(widths[p]);
      tx_idle = ($urandom_range(0, 3) != 0);
      rx_idle <= ($urandom_range(0, 3) != 0);
      repeat (PHASE_ITEMS) send_random();
      if (p == 4) begin
        // reads back to back while the output side holds off
        tx_idle = 1'b0;
        squeeze <= 1'b1;
        repeat (40) send_item(REQ_READ, hot_labels[$urandom_range(0, 7)], 8'($urandom),
                              8'($urandom));
      end
    end

    // closing stretch with no idling on either side
    settle();
    program_bin_width(8'($urandom_range(1, 255)));
    tx_idle = 1'b0;
    rx_idle <= 1'b0;
    repeat (60) send_random();
    settle();

    sb.finish_check();
    $display("summary: %0d transactions in (%0d reads), %0d results checked",
             items_sent, reads_sent, sb.checked);
    $display("summary: %0d bin width writes incl. 0, 1 and 255, one long output stall",
             widths_used);
    if (sb.errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
